// ----- rtl/core/clipped_color_key_blitter_core_defines.svh -----
// Assertion macros shared by the blitter core RTL.
`ifndef CLIPPED_COLOR_KEY_BLITTER_CORE_DEFINES_SVH
`define CLIPPED_COLOR_KEY_BLITTER_CORE_DEFINES_SVH

`ifndef SYNTH
// Checked outside reset
`define CCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every edge, reset included
`define CCB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CCB_ASSERT(lbl, prop, msg)
`define CCB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/ccb_pkg.sv -----
// Shared constants and types for the clipped colour-key blitter core.
package ccb_pkg;

  // Framebuffer size in pixels
  localparam int unsigned FB_WIDTH  = 256;
  localparam int unsigned FB_HEIGHT = 256;

  localparam int unsigned PIX_W    = 32;
  localparam int unsigned COORD_W  = 8;
  localparam int unsigned ORIGIN_W = 11;
  localparam int unsigned SIZE_W   = 10;
  localparam int unsigned POS_W    = ORIGIN_W + 1;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [PIX_W-1:0] ALPHA_MASK = 32'hff00_0000;
  localparam int unsigned      RGB_BYTES  = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEST_ORIGIN_X = 3'd0,
    CFG_DEST_ORIGIN_Y = 3'd1,
    CFG_RECT_WIDTH    = 3'd2,
    CFG_RECT_HEIGHT   = 3'd3,
    CFG_TINT_COLOR    = 3'd4
  } cfg_idx_t;

endpackage

// ----- rtl/core/ccb_src_if.sv -----
// Source pixel channel: valid/ready with one 32-bit pixel per beat.
interface ccb_src_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_pixel;

  modport source (output valid, output src_pixel, input ready);
  modport sink   (input valid, input src_pixel, output ready);
endinterface

// ----- rtl/core/ccb_res_if.sv -----
// Result channel: valid/ready with one framebuffer write per beat.
interface ccb_res_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [7:0]  out_x;
  logic [7:0]  out_y;
  logic [31:0] out_pixel;
  logic        rect_done;

  modport source (output valid, output write_enable, output out_x, output out_y,
                  output out_pixel, output rect_done, input ready);
  modport sink   (input valid, input write_enable, input out_x, input out_y,
                  input out_pixel, input rect_done, output ready);
endinterface

// ----- rtl/core/clipped_color_key_blitter_core.sv -----
// Clipped colour-key blitter core: source stream in, framebuffer writes out.
//
//  channel  | dir | handshake     | beat payload
//  ---------+-----+---------------+------------------------------------------
//  in_src   | in  | valid/ready   | src_pixel[31:0]
//  out_res  | out | valid/ready   | write_enable, out_x, out_y, out_pixel,
//           |     |               | rect_done
//  cfg_*    | in  | cfg_we only   | cfg_index[2:0], cfg_wdata[31:0]
//
// One pixel per clock sustained while out_res.ready is held high; each input
// beat passes through the input stage, then the result register, to its result beat.
// The input stage refills while a result waits, so one stalled beat does not
// stop the input side until both stages are full.
// rst_n is synchronous: it empties both stages, clears the counters and resets the registers.
`include "clipped_color_key_blitter_core_defines.svh"

module clipped_color_key_blitter_core
  import ccb_pkg::*;
#(
  parameter int unsigned FB_COLS = FB_WIDTH,
  parameter int unsigned FB_ROWS = FB_HEIGHT
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  ccb_src_if.sink               in_src,
  ccb_res_if.source             out_res
);

  localparam logic [POS_W-1:0] FB_W_LIM = POS_W'(FB_COLS);
  localparam logic [POS_W-1:0] FB_H_LIM = POS_W'(FB_ROWS);

  // Configuration registers
  logic signed [ORIGIN_W-1:0] origin_x_r, origin_y_r;
  logic [SIZE_W-1:0]          width_r, height_r;
  logic [PIX_W-1:0]           tint_r;

  // Raster counters
  logic [SIZE_W-1:0] col_r, row_r, col_nxt, row_nxt;

  // Input stage
  logic              s1_valid_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic [SIZE_W-1:0] s1_col_r, s1_row_r;
  logic              s1_done_r;

  // Result register
  logic              out_valid_r;
  logic              res_we_r, res_done_r;
  logic [COORD_W-1:0] res_x_r, res_y_r;
  logic [PIX_W-1:0]  res_pix_r;

  logic in_fire, s1_fire, s2_ready, in_ready;
  logic [SIZE_W-1:0] col_last, row_last;
  logic last_col, last_row;

  logic [POS_W-1:0] pos_x, pos_y;
  logic             in_fb, we;
  logic [PIX_W-1:0] tinted;

  // Store configuration writes; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      width_r    <= SIZE_W'(1);
      height_r   <= SIZE_W'(1);
      tint_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEST_ORIGIN_X: origin_x_r <= cfg_wdata[ORIGIN_W-1:0];
        CFG_DEST_ORIGIN_Y: origin_y_r <= cfg_wdata[ORIGIN_W-1:0];
        CFG_RECT_WIDTH:    width_r    <= cfg_wdata[SIZE_W-1:0];
        CFG_RECT_HEIGHT:   height_r   <= cfg_wdata[SIZE_W-1:0];
        CFG_TINT_COLOR:    tint_r     <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: each stage refills when it empties downstream
  assign s2_ready     = !out_valid_r || out_res.ready;
  assign in_ready     = !s1_valid_r || s2_ready;
  assign in_src.ready = in_ready;
  assign in_fire      = in_src.valid && in_ready;
  assign s1_fire      = s1_valid_r && s2_ready;

  // Last column/row; a zero size acts as one
  assign col_last = (width_r  == '0) ? '0 : width_r  - SIZE_W'(1);
  assign row_last = (height_r == '0) ? '0 : height_r - SIZE_W'(1);
  assign last_col = col_r >= col_last;
  assign last_row = row_r >= row_last;

  // Advance the raster position
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + SIZE_W'(1);
      end else begin
        col_nxt = col_r + SIZE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Capture the beat with its raster position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r  <= in_src.src_pixel;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
      s1_done_r <= last_col && last_row;
    end
  end

  // Destination position and clip test
  assign pos_x = {origin_x_r[ORIGIN_W-1], origin_x_r} + {2'b00, s1_col_r};
  assign pos_y = {origin_y_r[ORIGIN_W-1], origin_y_r} + {2'b00, s1_row_r};
  assign in_fb = !pos_x[POS_W-1] && (pos_x < FB_W_LIM) &&
                 !pos_y[POS_W-1] && (pos_y < FB_H_LIM);
  assign we    = in_fb && (s1_pix_r != '0);

  // Tint: copy, replace, or bytewise RGB add keeping alpha
  always_comb begin
    tinted = s1_pix_r;
    if (tint_r == '0) begin
      tinted = s1_pix_r;
    end else if ((tint_r & ALPHA_MASK) != '0) begin
      tinted = tint_r;
    end else begin
      tinted = s1_pix_r & ALPHA_MASK;
      for (int k = 0; k < RGB_BYTES; k++) begin
        tinted[8*k +: 8] = s1_pix_r[8*k +: 8] + tint_r[8*k +: 8];
      end
    end
  end

  // Result register; fields drop to zero when no write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_we_r   <= we;
      res_x_r    <= we ? pos_x[COORD_W-1:0] : '0;
      res_y_r    <= we ? pos_y[COORD_W-1:0] : '0;
      res_pix_r  <= we ? tinted : '0;
      res_done_r <= s1_done_r;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.write_enable = res_we_r;
  assign out_res.out_x        = res_x_r;
  assign out_res.out_y        = res_y_r;
  assign out_res.out_pixel    = res_pix_r;
  assign out_res.rect_done    = res_done_r;

  // Checks
  `CCB_ASSERT(a_nowrite_zero, (out_valid_r && !res_we_r) |-> (res_x_r == '0 && res_y_r == '0 && res_pix_r == '0), "fields not cleared on a beat without write")
  `CCB_ASSERT(a_rect_wrap, (in_fire && last_col && last_row) |=> (col_r == '0 && row_r == '0), "counters did not wrap after the last pixel")
  `CCB_ASSERT(a_s1_hold, (s1_valid_r && !s2_ready) |=> (s1_valid_r && $stable(s1_pix_r)), "input stage lost a held beat")
  `CCB_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!s1_valid_r && !out_valid_r), "pipeline not empty after reset")

endmodule
